// ===== hw/rtl/xsmd_pkg.sv =====
package xsmd_pkg;

  // Bytes and fields that the decoder recognises.
  localparam logic [7:0] OpsizePrefix = 8'h66;
  localparam logic [7:0] RexMask      = 8'hF0;
  localparam logic [7:0] RexPattern   = 8'h40;
  localparam logic [7:0] OpMovStore8  = 8'h88;
  localparam logic [7:0] OpMovStore   = 8'h89;
  localparam logic [7:0] OpMovLoad    = 8'h8B;
  localparam logic [7:0] OpEscape     = 8'h0F;
  localparam logic [7:0] OpMovzx8     = 8'hB6;
  localparam logic [7:0] OpMovzx16    = 8'hB7;
  localparam logic [2:0] RmSib        = 3'b100;
  localparam logic [2:0] BaseNoBase   = 3'b101;
  localparam logic [2:0] IndexNone    = 3'b100;
  localparam logic [1:0] ModRegister  = 2'b11;
  localparam logic [1:0] ModNoDisp    = 2'b00;
  localparam logic [1:0] ModDisp8     = 2'b01;
  localparam logic [2:0] Disp32Bytes  = 3'd4;
  localparam logic [2:0] Disp8Bytes   = 3'd1;

  // Access size codes.
  localparam logic [1:0] Size8  = 2'd0;
  localparam logic [1:0] Size16 = 2'd1;
  localparam logic [1:0] Size32 = 2'd2;
  localparam logic [1:0] Size64 = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_REX,
    PH_OPC,
    PH_ESC,
    PH_MODRM,
    PH_SIB,
    PH_DISP
  } phase_e;

  // Fields collected while an instruction is open.
  typedef struct packed {
    logic        opsize_seen;
    logic [3:0]  rex_bits;
    logic [1:0]  size_code;
    logic        write_flag;
    logic        zext_flag;
    logic [1:0]  mod_field;
    logic [3:0]  reg_num;
    logic [3:0]  base_num;
    logic [3:0]  index_num;
    logic [1:0]  scale_code;
    logic [31:0] disp_shift;
    logic [2:0]  disp_left;
    logic [3:0]  byte_count;
  } ctx_t;

  // Result word, last field in the lowest bits; the ok flag travels beside it.
  typedef struct packed {
    logic [2:0]         pad;
    logic [3:0]         insn_length;
    logic signed [31:0] disp_value;
    logic [3:0]         scale_factor;
    logic [3:0]         index_reg;
    logic [3:0]         base_reg;
    logic [3:0]         data_reg;
    logic [6:0]         access_bits;
    logic               zero_extend;
    logic               mem_write;
  } result_t;

endpackage

// ===== hw/rtl/x64_sib_mov_decoder.sv =====
// Channel   Direction  Word contents (lowest bit first)
// s_axis    in         tdata: code_byte[7:0]; tuser: start_req
// m_axis    out        tdata: mem_write, zero_extend, access_bits[6:0], data_reg[3:0],
//                      base_reg[3:0], index_reg[3:0], scale_factor[3:0],
//                      disp_value[31:0], insn_length[3:0], three zero bits; tuser: ok
//
// One byte is accepted per cycle while results are taken. A byte is decoded while it sits
// in the input register, and a result that it closes is written to the output register
// when that decode step runs. Decoding, and with it the input, waits whenever the output
// register holds a word that is not taken.
// Reset leaves the decoder idle, waiting for a start byte.
module x64_sib_mov_decoder
  import xsmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // code_byte[7:0]
  input  logic        s_axis_tuser_i,   // start_req
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // mem_write, zero_extend, access_bits, data_reg,
                                        // base_reg, index_reg, scale_factor, disp_value,
                                        // insn_length
  output logic        m_axis_tuser_o    // ok
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       out_free;
  logic       step;
  phase_e     phase_q, phase_d;
  ctx_t       ctx_q, ctx_d;
  logic       emit;
  logic       res_ok;
  result_t    res;
  logic       out_valid_q;
  logic       out_ok_q;
  result_t    out_q;

  // The decode step may run whenever a result it writes has somewhere to go.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
    end
  end

  // Byte decode: one phase step per byte, with fall-through for absent prefixes.
  always_comb begin
    phase_e ph;
    ctx_t   c;
    logic   done;
    logic [7:0] b;
    logic [1:0] wide;

    ph     = phase_q;
    c      = ctx_q;
    done   = 1'b0;
    b      = in_byte_q;
    emit   = 1'b0;
    res_ok = 1'b0;
    res    = '0;
    wide   = Size32;

    if (in_start_q) begin
      c  = '0;
      ph = PH_FIRST;
    end

    if (ph == PH_IDLE) begin
      done = 1'b1;
    end else begin
      c.byte_count = c.byte_count + 4'd1;
    end

    if (!done && ph == PH_FIRST) begin
      ph = PH_REX;
      if (b == OpsizePrefix) begin
        c.opsize_seen = 1'b1;
        done          = 1'b1;
      end
    end

    if (!done && ph == PH_REX) begin
      ph = PH_OPC;
      if ((b & RexMask) == RexPattern) begin
        c.rex_bits = b[3:0];
        done       = 1'b1;
      end
    end

    if (!done && ph == PH_OPC) begin
      done = 1'b1;
      wide = c.rex_bits[3] ? Size64 : Size32;
      ph   = PH_MODRM;
      case (b)
        OpMovStore8: begin
          c.write_flag = 1'b1;
          c.size_code  = Size8;
        end
        OpMovStore: begin
          c.write_flag = 1'b1;
          c.size_code  = c.opsize_seen ? Size16 : wide;
        end
        OpMovLoad: begin
          if (c.opsize_seen) begin
            emit = 1'b1;
            ph   = PH_IDLE;
          end else begin
            c.write_flag = 1'b0;
            c.size_code  = wide;
          end
        end
        OpEscape: begin
          ph = PH_ESC;
        end
        default: begin
          emit = 1'b1;
          ph   = PH_IDLE;
        end
      endcase
    end

    if (!done && ph == PH_ESC) begin
      done = 1'b1;
      if (b == OpMovzx8 || b == OpMovzx16) begin
        c.size_code  = (b == OpMovzx8) ? Size8 : Size16;
        c.write_flag = 1'b0;
        c.zext_flag  = 1'b1;
        ph           = PH_MODRM;
      end else begin
        emit = 1'b1;
        ph   = PH_IDLE;
      end
    end

    if (!done && ph == PH_MODRM) begin
      done        = 1'b1;
      c.mod_field = b[7:6];
      if (b[2:0] != RmSib || b[7:6] == ModRegister) begin
        emit = 1'b1;
        ph   = PH_IDLE;
      end else begin
        c.reg_num = {c.rex_bits[2], b[5:3]};
        ph        = PH_SIB;
      end
    end

    if (!done && ph == PH_SIB) begin
      done         = 1'b1;
      c.scale_code = b[7:6];
      if ((c.mod_field == ModNoDisp && b[2:0] == BaseNoBase)
          || (!c.rex_bits[1] && b[5:3] == IndexNone)) begin
        emit = 1'b1;
        ph   = PH_IDLE;
      end else begin
        c.index_num = {c.rex_bits[1], b[5:3]};
        c.base_num  = {c.rex_bits[0], b[2:0]};
        if (c.mod_field == ModNoDisp) begin
          emit           = 1'b1;
          ph             = PH_IDLE;
          res_ok         = 1'b1;
          res.disp_value = '0;
        end else begin
          c.disp_left  = (c.mod_field == ModDisp8) ? Disp8Bytes : Disp32Bytes;
          c.disp_shift = '0;
          ph           = PH_DISP;
        end
      end
    end

    if (!done && ph == PH_DISP) begin
      if (c.mod_field == ModDisp8) begin
        c.disp_left    = '0;
        emit           = 1'b1;
        ph             = PH_IDLE;
        res_ok         = 1'b1;
        res.disp_value = {{24{b[7]}}, b};
      end else begin
        c.disp_shift = {b, c.disp_shift[31:8]};
        c.disp_left  = c.disp_left - 3'd1;
        if (c.disp_left == '0) begin
          emit           = 1'b1;
          ph             = PH_IDLE;
          res_ok         = 1'b1;
          res.disp_value = c.disp_shift;
        end
      end
    end

    // A successful result carries the collected fields; a rejection stays all zero.
    if (res_ok) begin
      res.mem_write    = c.write_flag;
      res.zero_extend  = c.zext_flag;
      res.access_bits  = 7'd8 << c.size_code;
      res.data_reg     = c.reg_num;
      res.base_reg     = c.base_num;
      res.index_reg    = c.index_num;
      res.scale_factor = 4'd1 << c.scale_code;
      res.insn_length  = c.byte_count;
    end

    phase_d = ph;
    ctx_d   = c;
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ctx_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      ctx_q   <= ctx_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q    <= res;
      out_ok_q <= res_ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = out_ok_q;

  // A rejected word carries nothing but zeros.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_q == '0))
    else $error("rejected word has non-zero fields");

  // A decoded instruction has at least opcode, ModRM and SIB, and at most ten bytes.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> (out_q.insn_length >= 4'd3 && out_q.insn_length <= 4'd10))
    else $error("decoded length out of range");

  // Every word written closes the open instruction.
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit) |=> (phase_q == PH_IDLE))
    else $error("decoder still open after writing a word");

  // A word is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && emit) |-> (!out_valid_q || m_axis_tready_i))
    else $error("output word overwritten");

endmodule
